// ===== sv/mbps_pkg.sv =====
// shared types, constants and helpers of the masked byte pattern scanner
package mbps_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int PAT_BYTES   = 16;
    localparam int PAT_LEN_W   = 5;
    localparam int PAT_IDX_W   = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int COUNT_W     = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_LOW       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_HIGH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RESULT_LIMIT   = 3'd5;

    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } mbps_in_t;

    typedef struct packed {
        logic               result_kind;
        logic [COUNT_W-1:0] match_offset;
        logic [COUNT_W-1:0] match_count;
        logic               is_last;
    } mbps_out_t;

    // push request into the result queue
    typedef struct packed {
        logic [1:0] count;
        mbps_out_t  first;
        mbps_out_t  second;
    } mbps_push_t;

    function automatic logic [7:0] byte_sel(input logic [CFG_DATA_W-1:0] lo,
                                            input logic [CFG_DATA_W-1:0] hi,
                                            input logic [PAT_IDX_W-1:0] j);
        logic [2*CFG_DATA_W-1:0] both;
        both = {hi, lo};
        return both[8*j +: 8];
    endfunction

endpackage

// ===== sv/masked_byte_pattern_scanner.sv =====
// top level of the masked byte pattern scanner
//
// Scans a byte stream for a masked pattern of up to 16 bytes. Bytes arrive one per
// s_ beat; the last byte of a buffer carries end_of_buffer. A pattern byte matches
// when its mask byte is zero (wildcard) or when data AND mask equals the pattern byte.
// Each match gives one m_ beat with the start offset of the match in the buffer,
// until result_limit matches have been given (zero means no limit). The byte that
// ends the buffer also gives a summary beat with the match count, after any match
// of that byte, and clears the window and counters. A pattern length of zero, or
// above 16 or PATTERN_MAX, finds nothing. The block takes one byte per clock: the
// window is a row of PATTERN_MAX cells that shift each byte on and compare in
// parallel, and the counters update in the same cycle. Results go through a
// four-entry queue; s_ready drops only while fewer than two entries are free, so
// the one-byte-per-cycle rate holds as long as the result side takes one beat a
// cycle (a buffer end that also matches makes two beats). Configuration is written
// through cfg_wen, cfg_index and cfg_wdata and applies from the next byte; the user
// must write it only while the block is idle, which the block does not enforce.
module masked_byte_pattern_scanner #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mbps_pkg::mbps_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mbps_pkg::mbps_out_t                 m_data
);
    import mbps_pkg::*;

    // configuration registers
    logic [CFG_DATA_W-1:0] pattern_low_reg, pattern_high_reg;
    logic [CFG_DATA_W-1:0] mask_low_reg, mask_high_reg;
    logic [PAT_LEN_W-1:0]  pattern_length_reg;
    logic [COUNT_W-1:0]    result_limit_reg;

    // scan state
    logic [OFFSET_BITS-1:0] bytes_seen_reg, bytes_seen_next;
    logic [COUNT_W-1:0]     found_total_reg, found_total_next;
    logic                   limit_reached_reg, limit_reached_next;

    logic [OFFSET_BITS-1:0] seen_inc;
    logic [OFFSET_BITS-1:0] offset_full;
    logic [COUNT_W-1:0]     found_inc;
    logic                   s_fire;
    logic                   eob;
    logic                   len_ok;
    logic                   win_hit;
    logic                   match;
    logic                   space_ok;

    logic [7:0]             cell_in  [PATTERN_MAX];
    logic [7:0]             cell_out [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] cell_hit;

    mbps_out_t  match_res;
    mbps_out_t  sum_res;
    mbps_push_t push;

    assign s_ready = space_ok;
    assign s_fire  = s_valid && s_ready;
    assign eob     = s_data.end_of_buffer;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            mask_low_reg       <= '0;
            mask_high_reg      <= '0;
            pattern_length_reg <= '0;
            result_limit_reg   <= '0;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                REG_PATTERN_LOW:    pattern_low_reg    <= cfg_wdata;
                REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_wdata;
                REG_MASK_LOW:       mask_low_reg       <= cfg_wdata;
                REG_MASK_HIGH:      mask_high_reg      <= cfg_wdata;
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_wdata[PAT_LEN_W-1:0];
                REG_RESULT_LIMIT:   result_limit_reg   <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // window cells: cell 0 takes the new byte, each cell hands its byte on
    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        logic [7:0] pat_byte;
        logic [7:0] mask_byte;
        logic       in_use;

        if (i == 0) begin : g_head
            assign cell_in[i] = s_data.data_byte;
        end else begin : g_body
            assign cell_in[i] = cell_out[i-1];
        end

        // cell i holds the byte compared with pattern byte length-1-i
        if (i < PAT_BYTES) begin : g_used
            logic [PAT_IDX_W-1:0] pat_idx;
            assign in_use    = (pattern_length_reg > PAT_LEN_W'(i));
            assign pat_idx   = PAT_IDX_W'(pattern_length_reg - PAT_LEN_W'(i + 1));
            assign pat_byte  = byte_sel(pattern_low_reg, pattern_high_reg, pat_idx);
            assign mask_byte = byte_sel(mask_low_reg, mask_high_reg, pat_idx);
        end else begin : g_spare
            assign in_use    = 1'b0;
            assign pat_byte  = 8'd0;
            assign mask_byte = 8'd0;
        end

        mbps_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (s_fire),
            .clear     (eob),
            .byte_in   (cell_in[i]),
            .pat_byte  (pat_byte),
            .mask_byte (mask_byte),
            .in_use    (in_use),
            .byte_out  (cell_out[i]),
            .hit       (cell_hit[i])
        );
    end

    assign win_hit = &cell_hit;

    // length must be non-zero and fit both the pattern registers and the window
    assign len_ok = (pattern_length_reg != '0)
                 && (pattern_length_reg <= PAT_LEN_W'(PAT_BYTES))
                 && (int'(pattern_length_reg) <= PATTERN_MAX);

    // saturating byte count including this byte
    assign seen_inc = (bytes_seen_reg == '1) ? bytes_seen_reg
                                             : bytes_seen_reg + OFFSET_BITS'(1);

    assign match = len_ok && !limit_reached_reg && win_hit
                && (seen_inc >= OFFSET_BITS'(pattern_length_reg));

    assign found_inc   = (match && found_total_reg != '1) ? found_total_reg + COUNT_W'(1)
                                                          : found_total_reg;
    assign offset_full = seen_inc - OFFSET_BITS'(pattern_length_reg);

    always_comb begin
        bytes_seen_next    = bytes_seen_reg;
        found_total_next   = found_total_reg;
        limit_reached_next = limit_reached_reg;
        if (s_fire) begin
            if (eob) begin
                // buffer ends: start the next one from scratch
                bytes_seen_next    = '0;
                found_total_next   = '0;
                limit_reached_next = 1'b0;
            end else begin
                bytes_seen_next  = seen_inc;
                found_total_next = found_inc;
                if (match && result_limit_reg != '0 && found_inc >= result_limit_reg) begin
                    limit_reached_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_seen_reg    <= '0;
            found_total_reg   <= '0;
            limit_reached_reg <= 1'b0;
        end else begin
            bytes_seen_reg    <= bytes_seen_next;
            found_total_reg   <= found_total_next;
            limit_reached_reg <= limit_reached_next;
        end
    end

    // result beats for this byte: match first, then summary
    always_comb begin
        match_res.result_kind  = KIND_MATCH;
        match_res.match_offset = COUNT_W'(offset_full);
        match_res.match_count  = '0;
        match_res.is_last      = !eob;

        sum_res.result_kind  = KIND_SUMMARY;
        sum_res.match_offset = '0;
        sum_res.match_count  = found_inc;
        sum_res.is_last      = 1'b1;

        push.count  = s_fire ? (2'(match) + 2'(eob)) : 2'd0;
        push.first  = match ? match_res : sum_res;
        push.second = sum_res;
    end

    mbps_result_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .space_ok (space_ok),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );
endmodule

// ===== sv/mbps_cell.sv =====
// one window cell: holds a byte and compares the incoming byte with its pattern byte
module mbps_cell (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       shift_en,
    input  logic       clear,
    input  logic [7:0] byte_in,
    input  logic [7:0] pat_byte,
    input  logic [7:0] mask_byte,
    input  logic       in_use,
    output logic [7:0] byte_out,
    output logic       hit
);
    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // compare against the byte this cell holds after the shift
    assign hit = !in_use || (mask_byte == 8'd0) || ((byte_in & mask_byte) == pat_byte);

    always_comb begin
        byte_next = byte_reg;
        if (shift_en) begin
            byte_next = clear ? 8'd0 : byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'd0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;
endmodule

// ===== sv/mbps_result_queue.sv =====
// small result queue taking up to two results a cycle, head at a fixed place
module mbps_result_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  mbps_pkg::mbps_push_t push,
    output logic               space_ok,
    output logic               m_valid,
    input  logic               m_ready,
    output mbps_pkg::mbps_out_t m_data
);
    import mbps_pkg::*;

    mbps_out_t         q_reg  [QUEUE_DEPTH];
    mbps_out_t         q_next [QUEUE_DEPTH];
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic [QCNT_W-1:0] base_cnt;
    logic              pop;

    assign pop      = m_valid && m_ready;
    assign m_valid  = (count_reg != '0);
    assign m_data   = q_reg[0];
    assign space_ok = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    always_comb begin
        base_cnt = count_reg - QCNT_W'(pop);
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            q_next[k] = q_reg[k];
        end
        if (pop) begin
            for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
                q_next[k] = q_reg[k+1];
            end
        end
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (push.count != 2'd0 && QCNT_W'(k) == base_cnt) begin
                q_next[k] = push.first;
            end
            if (push.count == 2'd2 && QCNT_W'(k) == base_cnt + QCNT_W'(1)) begin
                q_next[k] = push.second;
            end
        end
        count_next = base_cnt + QCNT_W'(push.count);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            q_reg[k] <= q_next[k];
        end
    end
endmodule

// ===== tb/tb_masked_byte_pattern_scanner.sv =====
// testbench of the masked byte pattern scanner: directed and random byte streams, self-checking
`timescale 1ns / 1ps

module tb_masked_byte_pattern_scanner;
    import mbps_pkg::*;

    // clock, reset and ports of the block
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    mbps_in_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    mbps_out_t   m_data;

    // bytes waiting to be driven, and reports still owed by the block
    mbps_in_t    byte_stream [$];
    mbps_out_t   awaited_reports [$];
    int          items_left = 0;
    bit          byte_taken = 1'b0;
    int unsigned fails = 0;

    // pacing of both sides, in percent of cycles
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    // predictor copy of the registers
    logic [127:0] cfg_pat   = '0;
    logic [127:0] cfg_msk   = '0;
    logic [4:0]   cfg_len   = '0;
    logic [31:0]  cfg_limit = '0;

    // predictor copy of the scan state, index 0 holds the newest byte
    logic [7:0]   win [PAT_BYTES] = '{default: 8'h00};
    logic [31:0]  seen   = '0;
    logic [31:0]  found  = '0;
    bit           capped = 1'b0;

    masked_byte_pattern_scanner DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shift one accepted byte into the window and queue the reports it owes
    task automatic advance_window(input mbps_in_t beat);
        mbps_out_t  rep;
        logic [7:0] m, p, d;
        bit         hit;
        for (int i = PAT_BYTES - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = beat.data_byte;
        if (seen != '1) seen++;
        // zero length, oversized length, short buffer and a reached limit all give nothing
        hit = cfg_len != 0 && cfg_len <= PAT_BYTES && seen >= cfg_len && !capped;
        for (int j = 0; j < PAT_BYTES; j++) begin
            if (hit && j < cfg_len) begin
                m = cfg_msk[8*j +: 8];
                p = cfg_pat[8*j +: 8];
                // pattern byte 0 lines up with the oldest byte of the window
                d = win[cfg_len - 1 - j];
                if (m != 8'h00 && (d & m) != p) hit = 1'b0;
            end
        end
        if (hit) begin
            if (found != '1) found++;
            if (cfg_limit != 0 && found >= cfg_limit) capped = 1'b1;
            rep.result_kind  = KIND_MATCH;
            rep.match_offset = seen - cfg_len;
            rep.match_count  = '0;
            rep.is_last      = !beat.end_of_buffer;
            awaited_reports.push_back(rep);
        end
        // end of buffer: summary after any match, then the scan state starts afresh
        if (beat.end_of_buffer) begin
            rep.result_kind  = KIND_SUMMARY;
            rep.match_offset = '0;
            rep.match_count  = found;
            rep.is_last      = 1'b1;
            awaited_reports.push_back(rep);
            foreach (win[i]) win[i] = 8'h00;
            seen   = '0;
            found  = '0;
            capped = 1'b0;
        end
    endtask

    // compare one result beat with the oldest report owed
    task automatic check_report(input mbps_out_t got);
        mbps_out_t want;
        if (awaited_reports.size() == 0) begin
            $display("%0t: result beat with none owed, got %p", $time, got);
            fails++;
        end else begin
            want = awaited_reports.pop_front();
            if (got.result_kind !== want.result_kind) begin
                $display("%0t: result_kind expected %0d got %0d",
                         $time, want.result_kind, got.result_kind);
                fails++;
            end
            if (got.match_offset !== want.match_offset) begin
                $display("%0t: match_offset expected %0d got %0d",
                         $time, want.match_offset, got.match_offset);
                fails++;
            end
            if (got.match_count !== want.match_count) begin
                $display("%0t: match_count expected %0d got %0d",
                         $time, want.match_count, got.match_count);
                fails++;
            end
            if (got.is_last !== want.is_last) begin
                $display("%0t: is_last expected %0d got %0d",
                         $time, want.is_last, got.is_last);
                fails++;
            end
        end
    endtask

    // monitor: both handshakes are sampled at the rising edge
    always @(posedge aclk) begin
        byte_taken = aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) check_report(m_data);
        if (byte_taken) begin
            advance_window(s_data);
            items_left--;
        end
    end

    // driver: payload and ready change on the falling edge only
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || byte_taken) begin
            // previous beat gone, so offer the next one or idle
            if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data  <= byte_stream.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= $urandom_range(99) >= recv_stall_pct;
    end

    task automatic push_byte(input logic [7:0] value, input logic last);
        mbps_in_t beat;
        beat.data_byte     = value;
        beat.end_of_buffer = last;
        byte_stream.push_back(beat);
        items_left++;
    endtask

    // one register write per falling edge; the caller drops the enable afterwards
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
    endtask

    // all six registers, only ever called with the block idle
    task automatic program_scanner(input logic [127:0] pat, msk, input logic [4:0] len,
                                   input logic [31:0] lim);
        write_reg(REG_PATTERN_LOW,    pat[63:0]);
        write_reg(REG_PATTERN_HIGH,   pat[127:64]);
        write_reg(REG_MASK_LOW,       msk[63:0]);
        write_reg(REG_MASK_HIGH,      msk[127:64]);
        write_reg(REG_PATTERN_LENGTH, {59'd0, len});
        write_reg(REG_RESULT_LIMIT,   {32'd0, lim});
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        cfg_pat   = pat;
        cfg_msk   = msk;
        cfg_len   = len;
        cfg_limit = lim;
    endtask

    // a buffer of random bytes with copies of the pattern planted now and then
    task automatic queue_buffer(input int n, input bit close);
        logic [7:0] run [$];
        while (run.size() < n) begin
            if (cfg_len != 0 && $urandom_range(99) < 20) begin
                // free bits random, masked bits from the pattern
                for (int j = 0; j < cfg_len && j < PAT_BYTES; j++)
                    run.push_back((8'($urandom) & ~cfg_msk[8*j +: 8]) |
                                  (cfg_pat[8*j +: 8] & cfg_msk[8*j +: 8]));
            end else begin
                run.push_back(8'($urandom));
            end
        end
        foreach (run[k]) push_byte(run[k], close && k == run.size() - 1);
    endtask

    // buffers up to the quota; optionally the last one stays open across the next write
    task automatic queue_phase(input int quota, input bit leave_open);
        int issued;
        int n;
        issued = 0;
        while (issued < quota) begin
            n = $urandom_range(1, 40);
            queue_buffer(n, !(leave_open && issued + n >= quota));
            issued += n;
        end
    endtask

    // wait for every beat to be taken and every report to arrive, then let the queue settle
    task automatic wait_idle();
        while (items_left != 0 || awaited_reports.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_pace(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
        endcase
    endtask

    initial begin : stimulus
        logic [127:0] pat, msk;
        logic [4:0]   len;
        logic [31:0]  lim;
        int           r;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        set_pace(0);

        // directed: 3-byte pattern, exact byte, wildcard, high-nibble mask; limit of two
        program_scanner(128'h50_00_41, 128'hF0_00_FF, 5'd3, 32'd2);
        push_byte(8'h41, 1'b1);                                  // buffer shorter than pattern
        push_byte(8'h41, 1'b0); push_byte(8'h99, 1'b0); push_byte(8'h5A, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h41, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h5F, 1'b0);
        push_byte(8'h41, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'h50, 1'b0); // past limit
        push_byte(8'h00, 1'b1);
        // match on the closing byte: match beat then summary
        push_byte(8'h41, 1'b0); push_byte(8'h22, 1'b0); push_byte(8'h53, 1'b1);
        wait_idle();

        // zero length finds nothing even with every position a wildcard
        program_scanner('1, '0, 5'd0, 32'd0);
        push_byte(8'hAA, 1'b0); push_byte(8'h55, 1'b0); push_byte(8'h00, 1'b1);
        wait_idle();

        // length beyond the window finds nothing
        program_scanner('0, '0, 5'd31, '1);
        push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b1);
        wait_idle();

        // random phases cycling through the pacing modes
        for (int ph = 0; ph < 12; ph++) begin
            set_pace(ph % 4);
            if (ph == 0) begin
                // full width, all bits compared, pattern all ones, widest limit
                pat = '1;
                msk = '1;
                len = 5'd16;
                lim = '1;
            end else if (ph == 1) begin
                // single wildcard byte: every byte matches
                pat = {$urandom, $urandom, $urandom, $urandom};
                msk = '0;
                len = 5'd1;
                lim = '0;
            end else begin
                for (int j = 0; j < PAT_BYTES; j++) begin
                    r = $urandom_range(99);
                    msk[8*j +: 8] = (r < 30) ? 8'h00 : (r < 60) ? 8'hFF : 8'($urandom);
                    // mostly reachable pattern bytes, sometimes bits outside the mask
                    pat[8*j +: 8] = ($urandom_range(99) < 85) ? 8'($urandom) & msk[8*j +: 8]
                                                              : 8'($urandom);
                end
                if ($urandom_range(9) == 0) msk = '0;
                r = $urandom_range(99);
                len = (r < 8)  ? 5'd0 :
                      (r < 16) ? 5'd16 :
                      (r < 24) ? 5'($urandom_range(17, 31)) :
                      (r < 34) ? 5'($urandom_range(7, 15)) : 5'($urandom_range(1, 6));
                r = $urandom_range(99);
                lim = (r < 40) ? 32'd0 :
                      (r < 60) ? 32'd1 :
                      (r < 80) ? 32'($urandom_range(2, 5)) :
                      (r < 90) ? '1 : 32'($urandom);
            end
            program_scanner(pat, msk, len, lim);
            queue_phase(70, ph % 3 == 2);
            wait_idle();
        end

        // close any buffer left open, then give stray beats time to show up
        push_byte(8'($urandom), 1'b1);
        wait_idle();
        repeat (20) @(negedge aclk);
        if (fails == 0) begin
            $display("tb_masked_byte_pattern_scanner: clean");
        end else begin
            $display("tb_masked_byte_pattern_scanner: errors");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("tb_masked_byte_pattern_scanner: errors");
        $finish;
    end

endmodule
